// ===== hw/rtl/ssm_pkg.sv =====
// shared widths, codes and control types for the skid-steer mixer
package ssm_pkg;

    localparam int CMD_W          = 9;    // throttle and steering width
    localparam int MAG_W          = 10;   // magnitude of a sum of two commands
    localparam int DUTY_W         = 8;
    localparam int TOL_W          = 8;
    localparam int S_TDATA_W      = 24;
    localparam int M_TDATA_W      = 24;
    localparam int FULL_SCALE_DEF = 255;

    localparam logic [TOL_W-1:0]  TOL_RESET = 8'd15;
    localparam logic [DUTY_W-1:0] DUTY_MAX  = 8'hFF;
    localparam logic              DIR_FWD   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MULT,
        ST_INIT,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;     // take the input word
        logic mult;     // form duty * full scale
        logic init;     // seed the dividers
        logic step;     // one quotient bit
        logic finish;   // write the output register
    } cmd_t;

    typedef struct packed {
        logic need_scale;
        logic div_last;
        logic out_free;
    } status_t;

endpackage

// ===== hw/rtl/ssm_ctrl.sv =====
// controller state machine for the skid-steer mixer
module ssm_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  ssm_pkg::status_t status,
    output ssm_pkg::cmd_t    cmd
);

    ssm_pkg::state_t state_reg;
    ssm_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ssm_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ssm_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ssm_pkg::ST_MULT;
                end
            end
            ssm_pkg::ST_MULT: begin
                state_next = status.need_scale ? ssm_pkg::ST_INIT : ssm_pkg::ST_DONE;
            end
            ssm_pkg::ST_INIT: begin
                state_next = ssm_pkg::ST_DIV;
            end
            ssm_pkg::ST_DIV: begin
                if (status.div_last) begin
                    state_next = ssm_pkg::ST_DONE;
                end
            end
            ssm_pkg::ST_DONE: begin
                if (status.out_free) begin
                    state_next = ssm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ssm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ssm_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ssm_pkg::ST_MULT: begin
                cmd.mult = 1'b1;
            end
            ssm_pkg::ST_INIT: begin
                cmd.init = 1'b1;
            end
            ssm_pkg::ST_DIV: begin
                cmd.step = 1'b1;
            end
            ssm_pkg::ST_DONE: begin
                cmd.finish = status.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== hw/rtl/ssm_dpath.sv =====
// datapath: direction logic, mixing, two bit-serial dividers and output register
module ssm_dpath #(
    parameter int FULL_SCALE = ssm_pkg::FULL_SCALE_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [ssm_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                            cfg_valid,
    input  logic [ssm_pkg::TOL_W-1:0]       cfg_data,
    input  ssm_pkg::cmd_t                   cmd,
    output ssm_pkg::status_t                status,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ssm_pkg::M_TDATA_W-1:0]   m_tdata
);

    localparam int FSW = $clog2(FULL_SCALE + 1);
    localparam int PW  = ssm_pkg::MAG_W + FSW;
    localparam int CW  = $clog2(FSW);
    localparam int MW  = ssm_pkg::MAG_W;
    localparam int DW  = ssm_pkg::DUTY_W;

    logic signed [ssm_pkg::CMD_W-1:0] thr;
    logic signed [ssm_pkg::CMD_W-1:0] str;
    logic signed [MW-1:0]             sum;
    logic signed [MW-1:0]             dif;
    logic [ssm_pkg::CMD_W-1:0]        thr_mag;
    logic [MW-1:0]                    lmag_next;
    logic [MW-1:0]                    rmag_next;
    logic                             neutral;
    logic                             ldir_next;
    logic                             rdir_next;

    logic [ssm_pkg::TOL_W-1:0] tol_reg;
    logic                      last_l_reg;
    logic                      last_r_reg;
    logic                      ldir_reg;
    logic                      rdir_reg;
    logic                      lstop_reg;
    logic                      rstop_reg;
    logic [MW-1:0]             lmag_reg;
    logic [MW-1:0]             rmag_reg;
    logic [MW-1:0]             mx_reg;
    logic                      scale_reg;
    logic [PW-1:0]             lprod_reg;
    logic [PW-1:0]             rprod_reg;
    logic [MW-1:0]             lrem_reg;
    logic [MW-1:0]             rrem_reg;
    logic [FSW-1:0]            lq_reg;
    logic [FSW-1:0]            rq_reg;
    logic [CW-1:0]             cnt_reg;
    logic                      m_valid_reg;
    logic [ssm_pkg::M_TDATA_W-1:0] m_data_reg;

    logic [MW:0]    ltrial;
    logic [MW:0]    rtrial;
    logic [MW:0]    ldiff;
    logic [MW:0]    rdiff;
    logic           lge;
    logic           rge;
    logic [MW-1:0]  lrem_next;
    logic [MW-1:0]  rrem_next;
    logic [PW-1:0]  lval;
    logic [PW-1:0]  rval;
    logic [DW-1:0]  lduty;
    logic [DW-1:0]  rduty;

    assign thr = s_tdata[ssm_pkg::CMD_W-1:0];
    assign str = s_tdata[2*ssm_pkg::CMD_W-1:ssm_pkg::CMD_W];
    assign sum = MW'(thr) + MW'(str);
    assign dif = MW'(thr) - MW'(str);
    assign thr_mag   = thr[ssm_pkg::CMD_W-1] ? ssm_pkg::CMD_W'(-thr) : ssm_pkg::CMD_W'(thr);
    assign lmag_next = sum[MW-1] ? MW'(-sum) : MW'(sum);
    assign rmag_next = dif[MW-1] ? MW'(-dif) : MW'(dif);
    assign neutral   = thr_mag <= ssm_pkg::CMD_W'(tol_reg);
    // point turn in neutral, otherwise throttle sign on both sides
    assign ldir_next = neutral ? ~str[ssm_pkg::CMD_W-1] : ~thr[ssm_pkg::CMD_W-1];
    assign rdir_next = neutral ? str[ssm_pkg::CMD_W-1]  : ~thr[ssm_pkg::CMD_W-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg    <= ssm_pkg::TOL_RESET;
            last_l_reg <= ssm_pkg::DIR_FWD;
            last_r_reg <= ssm_pkg::DIR_FWD;
        end else begin
            if (cfg_valid) begin
                tol_reg <= cfg_data;
            end
            if (cmd.load) begin
                last_l_reg <= ldir_next;
                last_r_reg <= rdir_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            ldir_reg  <= ldir_next;
            rdir_reg  <= rdir_next;
            lstop_reg <= ldir_next ^ last_l_reg;
            rstop_reg <= rdir_next ^ last_r_reg;
            lmag_reg  <= lmag_next;
            rmag_reg  <= rmag_next;
            mx_reg    <= (lmag_next > rmag_next) ? lmag_next : rmag_next;
            scale_reg <= PW'((lmag_next > rmag_next) ? lmag_next : rmag_next)
                         > PW'(FULL_SCALE);
        end
        if (cmd.mult) begin
            lprod_reg <= PW'(lmag_reg) * PW'(FULL_SCALE);
            rprod_reg <= PW'(rmag_reg) * PW'(FULL_SCALE);
        end
    end

    // restoring division; the quotient fits in FSW bits since it never exceeds full scale
    assign ltrial = {lrem_reg, lq_reg[FSW-1]};
    assign rtrial = {rrem_reg, rq_reg[FSW-1]};
    assign ldiff  = ltrial - (MW+1)'(mx_reg);
    assign rdiff  = rtrial - (MW+1)'(mx_reg);
    assign lge    = ltrial >= (MW+1)'(mx_reg);
    assign rge    = rtrial >= (MW+1)'(mx_reg);
    assign lrem_next = lge ? ldiff[MW-1:0] : ltrial[MW-1:0];
    assign rrem_next = rge ? rdiff[MW-1:0] : rtrial[MW-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.init) begin
            lrem_reg <= lprod_reg[PW-1:FSW];
            rrem_reg <= rprod_reg[PW-1:FSW];
            lq_reg   <= lprod_reg[FSW-1:0];
            rq_reg   <= rprod_reg[FSW-1:0];
            cnt_reg  <= '0;
        end else if (cmd.step) begin
            lrem_reg <= lrem_next;
            rrem_reg <= rrem_next;
            lq_reg   <= {lq_reg[FSW-2:0], lge};
            rq_reg   <= {rq_reg[FSW-2:0], rge};
            cnt_reg  <= cnt_reg + CW'(1);
        end
    end

    assign lval  = scale_reg ? PW'(lq_reg) : PW'(lmag_reg);
    assign rval  = scale_reg ? PW'(rq_reg) : PW'(rmag_reg);
    assign lduty = (lval > PW'(ssm_pkg::DUTY_MAX)) ? ssm_pkg::DUTY_MAX : lval[DW-1:0];
    assign rduty = (rval > PW'(ssm_pkg::DUTY_MAX)) ? ssm_pkg::DUTY_MAX : rval[DW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            m_data_reg <= {4'b0, rstop_reg, rduty, rdir_reg, lstop_reg, lduty, ldir_reg};
        end
    end

    assign status.need_scale = scale_reg;
    assign status.div_last   = cnt_reg == CW'(FSW - 1);
    assign status.out_free   = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ===== hw/rtl/skid_steer_mixer_top.sv =====
// skid-steer mixer: an accepted word is loaded; its result enters the output register without
// division when no scaling is needed, or after the two bit-serial dividers, one quotient bit per
// cycle, when the larger magnitude exceeds full scale (FSW, the bit width of FULL_SCALE, quotient
// bits). A result enters only once the register is free or m_tready is high; the next word is
// accepted after that, even while the previous result waits in the output register.
// aresetn is synchronous, active low: tolerance returns to 15, both stored directions to forward.
module skid_steer_mixer_top #(
    parameter int FULL_SCALE = ssm_pkg::FULL_SCALE_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // throttle [8:0], steering [17:9]
    input  logic [ssm_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // left_forward [0], left_duty [8:1], left_stop_first [9],
    // right_forward [10], right_duty [18:11], right_stop_first [19]
    output logic [ssm_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    // neutral_tolerance
    input  logic [ssm_pkg::TOL_W-1:0]     cfg_data
);

    ssm_pkg::cmd_t    cmd;
    ssm_pkg::status_t status;

    assign cfg_ready = 1'b1;

    ssm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ssm_dpath #(
        .FULL_SCALE (FULL_SCALE)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
